// File: design/mcmq_pkg.sv
// shared constants, types and helpers for the multi-core mailbox queues
package mcmq_pkg;

  localparam int CORE_COUNT = 4;
  localparam int RING_DEPTH = 256;
  localparam int MASK_W     = 4;
  localparam int CORE_W     = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int RING_W     = $clog2(RING_DEPTH);
  localparam int SLOTS      = CORE_COUNT * RING_DEPTH;
  localparam int SLOT_W     = $clog2(SLOTS);

  localparam logic [MASK_W-1:0] MASK_RESET    = '1;
  localparam logic [2:0]        TYPE_SHUTDOWN = 3'd6;
  localparam logic              KIND_SEND     = 1'b0;
  localparam logic              KIND_RECV     = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_SHUTDOWN = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  source_core;
    logic [2:0]  target_core;
    logic [2:0]  message_type;
    logic [63:0] payload_word;
    logic [1:0]  receiving_core;
    logic [47:0] now_time;
  } item_t;

  typedef struct packed {
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [2:0]  typ;
    logic [31:0] seq;
    logic [63:0] payload;
    logic [47:0] stamp;
  } msg_t;

  localparam int MSG_W = $bits(msg_t);

  typedef struct packed {
    status_t     status;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [2:0]  typ;
    logic [31:0] seq;
    logic [63:0] payload;
    logic [47:0] stamp;
    logic [31:0] sent_total;
    logic [31:0] received_total;
    logic [63:0] latency_total;
  } result_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    msg_t              wdata;
  } ram_req_t;

  function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] i);
    logic [RING_W-1:0] r;
    if (i == RING_W'(RING_DEPTH - 1)) r = '0;
    else r = i + RING_W'(1);
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_addr(input logic [CORE_W-1:0] c,
                                                  input logic [RING_W-1:0] i);
    return SLOT_W'(SLOT_W'(c) * SLOT_W'(RING_DEPTH)) + SLOT_W'(i);
  endfunction

endpackage

// File: design/multi_core_mailbox_queues_top.sv
// top level: mailbox sequencer, message memory, mask register and output register
// a send or unsuccessful receive goes through the execute and done states, then the output register;
//   a successful receive adds a message memory read and a latency add before done
// the sequencer takes no new item until the result of the last one has left its done state
// reset: ring pointers, counters and latency sums cleared, running mask set to all ones
// the message memory is not cleared; only slots between head and tail are read
module multi_core_mailbox_queues_top import mcmq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [1:0]  in_source_core,
  input  logic [2:0]  in_target_core,
  input  logic [2:0]  in_message_type,
  input  logic [63:0] in_payload_word,
  input  logic [1:0]  in_receiving_core,
  input  logic [47:0] in_now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_source,
  output logic [1:0]  out_dest,
  output logic [2:0]  out_type,
  output logic [31:0] out_sequence,
  output logic [63:0] out_payload,
  output logic [47:0] out_stamp,
  output logic [31:0] out_sent_total,
  output logic [31:0] out_received_total,
  output logic [63:0] out_latency_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_core_running_mask
);

  item_t             item;
  result_t           res, out_res_r;
  logic              res_valid, res_ready;
  logic              out_valid_r;
  logic [MASK_W-1:0] mask_r;
  ram_req_t          ram_req;
  logic [MSG_W-1:0]  ram_rdata;

  assign item.kind           = in_kind;
  assign item.source_core    = in_source_core;
  assign item.target_core    = in_target_core;
  assign item.message_type   = in_message_type;
  assign item.payload_word   = in_payload_word;
  assign item.receiving_core = in_receiving_core;
  assign item.now_time       = in_now_time;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;

  mcmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item      (item),
    .mask      (mask_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (msg_t'(ram_rdata))
  );

  mcmq_ram #(
    .WIDTH (MSG_W),
    .DEPTH (SLOTS)
  ) u_msg_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) mask_r <= MASK_W'(cfg_core_running_mask);
      if (res_ready) out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_res_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_source         = out_res_r.src;
  assign out_dest           = out_res_r.dst;
  assign out_type           = out_res_r.typ;
  assign out_sequence       = out_res_r.seq;
  assign out_payload        = out_res_r.payload;
  assign out_stamp          = out_res_r.stamp;
  assign out_sent_total     = out_res_r.sent_total;
  assign out_received_total = out_res_r.received_total;
  assign out_latency_total  = out_res_r.latency_total;

endmodule

// File: design/mcmq_ram.sv
// generic single-clock ram with one write port and one registered read port
module mcmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/mcmq_ctrl.sv
// item sequencer with per-core ring pointers, counters and latency sums
module mcmq_ctrl import mcmq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  item_t             item,
  input  logic [MASK_W-1:0] mask,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res,
  output ram_req_t          ram_req,
  input  msg_t              ram_rdata
);

  state_t  state_r, state_nxt;
  item_t   item_r, item_nxt;
  result_t res_r, res_nxt;
  logic [47:0] delta_r, delta_nxt;

  logic [RING_W-1:0] head_r [CORE_COUNT];
  logic [RING_W-1:0] tail_r [CORE_COUNT];
  logic [31:0]       sent_r [CORE_COUNT];
  logic [31:0]       recv_r [CORE_COUNT];
  logic [63:0]       lat_r  [CORE_COUNT];

  logic              head_we, tail_we, sent_we, recv_we, lat_we;
  logic [RING_W-1:0] head_nxt, tail_nxt;
  logic [31:0]       sent_nxt, recv_nxt;
  logic [63:0]       lat_nxt;

  logic              is_recv, bad, running, empty, full, recv_hit;
  logic [CORE_W-1:0] csel, ssel;
  logic [RING_W-1:0] head_c, tail_c, tail_inc;

  assign is_recv  = (item_r.kind == KIND_RECV);
  assign csel     = is_recv ? CORE_W'(item_r.receiving_core) : CORE_W'(item_r.target_core);
  assign ssel     = CORE_W'(item_r.source_core);
  assign bad      = is_recv ? (32'(item_r.receiving_core) >= CORE_COUNT)
                            : ((32'(item_r.target_core) >= CORE_COUNT) ||
                               (32'(item_r.source_core) >= CORE_COUNT));
  assign running  = (32'(csel) >= MASK_W) || (|(mask & (MASK_W'(1) << csel)));
  assign head_c   = head_r[csel];
  assign tail_c   = tail_r[csel];
  assign tail_inc = ring_next(tail_c);
  assign empty    = (head_c == tail_c);
  assign full     = (tail_inc == head_c);
  assign recv_hit = is_recv && !bad && running && !empty;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = recv_hit ? S_READ : S_DONE;
      S_READ: state_nxt = S_ACC;
      S_ACC:  state_nxt = S_DONE;
      S_DONE: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    item_nxt  = item_r;
    res_nxt   = res_r;
    delta_nxt = delta_r;
    ram_req   = '0;
    head_we   = 1'b0;
    tail_we   = 1'b0;
    sent_we   = 1'b0;
    recv_we   = 1'b0;
    lat_we    = 1'b0;
    head_nxt  = ring_next(head_c);
    tail_nxt  = tail_inc;
    sent_nxt  = sent_r[ssel] + 32'd1;
    recv_nxt  = recv_r[csel] + 32'd1;
    lat_nxt   = lat_r[csel] + 64'(delta_r);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) item_nxt = item;
      end
      S_EXEC: begin
        res_nxt = '0;
        res_nxt.status = ST_OK;
        if (bad) begin
          res_nxt.status = ST_BAD;
        end else if (!is_recv) begin
          if (full) begin
            res_nxt.status     = ST_FULL;
            res_nxt.sent_total = sent_r[ssel];
          end else begin
            ram_req.we            = 1'b1;
            ram_req.addr          = slot_addr(csel, tail_c);
            ram_req.wdata.src     = item_r.source_core;
            ram_req.wdata.dst     = item_r.target_core[1:0];
            ram_req.wdata.typ     = item_r.message_type;
            ram_req.wdata.seq     = sent_r[ssel];
            ram_req.wdata.payload = item_r.payload_word;
            ram_req.wdata.stamp   = item_r.now_time;
            tail_we               = 1'b1;
            sent_we               = 1'b1;
            res_nxt.sent_total    = sent_nxt;
          end
        end else begin
          res_nxt.received_total = recv_r[csel];
          res_nxt.latency_total  = lat_r[csel];
          if (!running) begin
            res_nxt.status = ST_SHUTDOWN;
            res_nxt.typ    = TYPE_SHUTDOWN;
          end else if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            ram_req.re     = 1'b1;
            ram_req.addr   = slot_addr(csel, head_c);
            head_we        = 1'b1;
            recv_we        = 1'b1;
          end
        end
      end
      S_READ: begin
        res_nxt.src     = ram_rdata.src;
        res_nxt.dst     = ram_rdata.dst;
        res_nxt.typ     = ram_rdata.typ;
        res_nxt.seq     = ram_rdata.seq;
        res_nxt.payload = ram_rdata.payload;
        res_nxt.stamp   = ram_rdata.stamp;
        delta_nxt = (item_r.now_time > ram_rdata.stamp) ?
                    (item_r.now_time - ram_rdata.stamp) : 48'd0;
      end
      S_ACC: begin
        lat_we                 = 1'b1;
        res_nxt.received_total = recv_r[csel];
        res_nxt.latency_total  = lat_nxt;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int c = 0; c < CORE_COUNT; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        sent_r[c] <= '0;
        recv_r[c] <= '0;
        lat_r[c]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (head_we) head_r[csel] <= head_nxt;
      if (tail_we) tail_r[csel] <= tail_nxt;
      if (sent_we) sent_r[ssel] <= sent_nxt;
      if (recv_we) recv_r[csel] <= recv_nxt;
      if (lat_we)  lat_r[csel]  <= lat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    delta_r <= delta_nxt;
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("ram read and write in the same cycle");

  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (tail_inc != head_c) && !is_recv)
    else $error("message written into a full ring");

  a_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.re |-> (head_c != tail_c) && running)
    else $error("message read from an empty or stopped ring");

  a_read_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> $past(state_r) == S_EXEC && $past(ram_req.re))
    else $error("read data used without a read");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("transfer not followed by execution");

endmodule

// File: bench/multi_core_mailbox_queues_top_test.sv
// self-checking testbench for the multi-core mailbox queues top level
`timescale 1ns / 1ps

module multi_core_mailbox_queues_top_test;
  import mcmq_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int FINAL_CYCLES  = 16;
  localparam int FILL_SENDS    = 262;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [1:0]  out_source;
  logic [1:0]  out_dest;
  logic [2:0]  out_type;
  logic [31:0] out_sequence;
  logic [63:0] out_payload;
  logic [47:0] out_stamp;
  logic [31:0] out_sent_total;
  logic [31:0] out_received_total;
  logic [63:0] out_latency_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_mask = '0;

  item_t       offer = '0;
  item_t       pending_items[$];
  result_t     expected_results[$];

  // mailbox state as the block should hold it
  msg_t              ring_msg [CORE_COUNT][RING_DEPTH];
  logic [RING_W-1:0] ring_head [CORE_COUNT];
  logic [RING_W-1:0] ring_tail [CORE_COUNT];
  logic [31:0]       sent_count [CORE_COUNT];
  logic [31:0]       recv_count [CORE_COUNT];
  logic [63:0]       latency_acc [CORE_COUNT];
  logic [3:0]        running_mask;

  logic [47:0] wall_clock = 48'd4000;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_taken = 1'b0;
  logic [15:0] hold_left = '0;
  int          failures = 0;
  int          items_accepted = 0;
  int          results_checked = 0;
  int          status_count [8];
  int          cycle_count = 0;
  int          focus_core;
  int          focus_net;

  multi_core_mailbox_queues_top i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (offer.kind),
    .in_source_core        (offer.source_core),
    .in_target_core        (offer.target_core),
    .in_message_type       (offer.message_type),
    .in_payload_word       (offer.payload_word),
    .in_receiving_core     (offer.receiving_core),
    .in_now_time           (offer.now_time),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_source            (out_source),
    .out_dest              (out_dest),
    .out_type              (out_type),
    .out_sequence          (out_sequence),
    .out_payload           (out_payload),
    .out_stamp             (out_stamp),
    .out_sent_total        (out_sent_total),
    .out_received_total    (out_received_total),
    .out_latency_total     (out_latency_total),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_core_running_mask (cfg_mask)
  );

  always #2 clk = ~clk;

  function automatic result_t mailbox_outcome(input item_t it);
    result_t           r;
    msg_t              m;
    logic [RING_W-1:0] nxt;
    int unsigned       c;
    int unsigned       s;
    r = '0;
    if (it.kind == KIND_SEND) begin
      if (it.target_core >= CORE_COUNT || it.source_core >= CORE_COUNT) begin
        r.status = ST_BAD;
      end else begin
        c = it.target_core;
        s = it.source_core;
        nxt = RING_W'((int'(ring_tail[c]) + 1) % RING_DEPTH);
        if (nxt == ring_head[c]) begin
          r.status = ST_FULL;
        end else begin
          m.src = it.source_core;
          m.dst = it.target_core[1:0];
          m.typ = it.message_type;
          m.seq = sent_count[s];
          m.payload = it.payload_word;
          m.stamp = it.now_time;
          ring_msg[c][ring_tail[c]] = m;
          ring_tail[c] = nxt;
          sent_count[s] = sent_count[s] + 32'd1;
          r.status = ST_OK;
        end
        r.sent_total = sent_count[s];
      end
    end else begin
      if (it.receiving_core >= CORE_COUNT) begin
        r.status = ST_BAD;
      end else begin
        c = it.receiving_core;
        if (!running_mask[c]) begin
          r.status = ST_SHUTDOWN;
          r.typ = TYPE_SHUTDOWN;
        end else if (ring_head[c] == ring_tail[c]) begin
          r.status = ST_EMPTY;
        end else begin
          m = ring_msg[c][ring_head[c]];
          ring_head[c] = RING_W'((int'(ring_head[c]) + 1) % RING_DEPTH);
          recv_count[c] = recv_count[c] + 32'd1;
          // stamps at or after the receive time add nothing
          if (it.now_time > m.stamp) latency_acc[c] = latency_acc[c] + 64'(it.now_time - m.stamp);
          r.status = ST_OK;
          r.src = m.src;
          r.dst = m.dst;
          r.typ = m.typ;
          r.seq = m.seq;
          r.payload = m.payload;
          r.stamp = m.stamp;
        end
        r.received_total = recv_count[c];
        r.latency_total = latency_acc[c];
      end
    end
    return r;
  endfunction

  function automatic logic [47:0] next_stamp();
    if ($urandom_range(0, 15) == 0) return 48'({$urandom_range(0, 65535), $urandom});
    wall_clock = wall_clock + 48'($urandom_range(1, 40));
    return wall_clock;
  endfunction

  function automatic item_t random_item(input int unsigned recv_pct, input int focus,
                                        input int unsigned focus_pct);
    item_t it;
    it.kind = ($urandom_range(0, 99) < recv_pct) ? KIND_RECV : KIND_SEND;
    it.source_core = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) it.target_core = 3'($urandom_range(CORE_COUNT, 7));
    else if (focus >= 0 && $urandom_range(0, 99) < focus_pct) it.target_core = 3'(focus);
    else it.target_core = 3'($urandom_range(0, CORE_COUNT - 1));
    it.message_type = 3'($urandom_range(0, 7));
    it.payload_word = {$urandom, $urandom};
    if (focus >= 0 && $urandom_range(0, 99) < focus_pct) it.receiving_core = 2'(focus);
    else it.receiving_core = 2'($urandom_range(0, 3));
    it.now_time = next_stamp();
    return it;
  endfunction

  task automatic queue_item(input logic kind, input logic [1:0] src, input logic [2:0] dst,
                            input logic [2:0] typ, input logic [63:0] pay,
                            input logic [1:0] rcv, input logic [47:0] now);
    item_t it;
    it.kind = kind;
    it.source_core = src;
    it.target_core = dst;
    it.message_type = typ;
    it.payload_word = pay;
    it.receiving_core = rcv;
    it.now_time = now;
    pending_items.push_back(it);
  endtask

  task automatic check_field(input string field, input logic [63:0] want_val,
                             input logic [63:0] got_val);
    if (want_val !== got_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want_val, got_val);
      failures++;
    end
  endtask

  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_running_mask(input logic [3:0] mask);
    @(posedge clk);
    cfg_mask <= mask;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    running_mask = mask;
    cfg_valid <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(mailbox_outcome(offer));
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offer <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= '0;
      hold_taken <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_left <= 16'(HOLD_CYCLES);
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 16'd1;
    end
  end

  // monitor
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        status_count[out_status]++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected, status %0d", out_status);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("source", 64'(want.src), 64'(out_source));
          check_field("dest", 64'(want.dst), 64'(out_dest));
          check_field("type", 64'(want.typ), 64'(out_type));
          check_field("sequence", 64'(want.seq), 64'(out_sequence));
          check_field("payload", want.payload, out_payload);
          check_field("stamp", 64'(want.stamp), 64'(out_stamp));
          check_field("sent_total", 64'(want.sent_total), 64'(out_sent_total));
          check_field("received_total", 64'(want.received_total), 64'(out_received_total));
          check_field("latency_total", want.latency_total, out_latency_total);
        end
        results_checked++;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** multi_core_mailbox_queues_top: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < CORE_COUNT; c++) begin
      ring_head[c] = '0;
      ring_tail[c] = '0;
      sent_count[c] = '0;
      recv_count[c] = '0;
      latency_acc[c] = '0;
    end
    for (int k = 0; k < 8; k++) status_count[k] = 0;
    running_mask = MASK_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty rings, field extremes, bad destinations, future and equal stamps
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd0, 48'd0);
    queue_item(KIND_SEND, 2'd0, 3'd0, 3'd0, 64'd0, 2'd0, 48'd0);
    queue_item(KIND_SEND, 2'd3, 3'd3, 3'd7, '1, 2'd3, '1);
    queue_item(KIND_SEND, 2'd1, 3'd4, 3'd1, 64'd5, 2'd0, 48'd10);
    queue_item(KIND_SEND, 2'd2, 3'd7, 3'd6, '1, 2'd0, 48'd20);
    queue_item(KIND_SEND, 2'd2, 3'd1, 3'd6, 64'h0123_4567_89ab_cdef, 2'd0, 48'd1000);
    queue_item(KIND_SEND, 2'd1, 3'd2, 3'd3, 64'ha5a5_5a5a_f00f_0ff0, 2'd0, 48'd2000);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd0, 48'd5);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd3, 48'd100);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd1, 48'd1000);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd2, '1);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd2, 48'd3000);
    queue_item(KIND_SEND, 2'd0, 3'd3, 3'd5, 64'h8000_0000_0000_0001, 2'd0, 48'd3000);
    queue_item(KIND_SEND, 2'd0, 3'd3, 3'd2, 64'h7fff_ffff_ffff_fffe, 2'd0, 48'd3001);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd3, 48'd3500);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd3, 48'd3600);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd3, 48'd3700);
    queue_item(KIND_RECV, 2'd0, 3'd0, 3'd0, 64'd0, 2'd1, 48'd3800);
    wait_quiet();

    // all cores stopped: receives shut down, sends still land
    write_running_mask(4'b0000);
    send_idle_pct = 57;
    recv_stall_pct = 0;
    repeat (30) pending_items.push_back(random_item(50, -1, 0));
    wait_quiet();

    write_running_mask(4'b1010);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    repeat (45) pending_items.push_back(random_item(45, -1, 0));
    wait_quiet();

    // fill one inbox until sends get dropped, receiver held off at first
    write_running_mask(4'b1111);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    focus_core = $urandom_range(0, CORE_COUNT - 1);
    focus_net = 0;
    hold_go <= 1'b1;
    while (focus_net < FILL_SENDS) begin
      item_t it;
      it = random_item(4, focus_core, 96);
      if (it.kind == KIND_SEND && it.target_core == focus_core) focus_net++;
      if (it.kind == KIND_RECV && it.receiving_core == focus_core) focus_net--;
      pending_items.push_back(it);
    end
    wait_quiet();

    // partial drain with sends mixed in so the tail wraps
    write_running_mask(4'($urandom_range(0, 15)) | 4'(1 << focus_core));
    send_idle_pct = 38;
    recv_stall_pct = 38;
    repeat (40) pending_items.push_back(random_item(60, focus_core, 80));
    wait_quiet();

    repeat (FINAL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    $display("run covered %0d items and %0d results over five mask settings, one inbox filled",
             items_accepted, results_checked);
    $display("statuses seen: ok %0d, full %0d, bad core %0d, empty %0d, shutdown %0d",
             status_count[ST_OK], status_count[ST_FULL], status_count[ST_BAD],
             status_count[ST_EMPTY], status_count[ST_SHUTDOWN]);
    if (failures == 0) begin
      $display("** multi_core_mailbox_queues_top: PASSED **");
    end else begin
      $display("** multi_core_mailbox_queues_top: FAILED **");
    end
    $finish;
  end

endmodule
